>>> src/polyblep_saw_oscillator_glide_assert.svh
// Assertion macros used by the oscillator checker.
`ifndef POLYBLEP_SAW_OSCILLATOR_GLIDE_ASSERT_SVH
`define POLYBLEP_SAW_OSCILLATOR_GLIDE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define PBSAW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pbsaw assertion failed");

// Next-cycle implication, off while reset is asserted.
`define PBSAW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pbsaw assertion failed");

// Next-cycle implication that also holds through reset.
`define PBSAW_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pbsaw assertion failed");

`endif

>>> src/pbsaw_pkg.sv
// Package: constants, register indexes and pitch ratio table of the oscillator.
package pbsaw_pkg;

    localparam int PHASE_W     = 32;
    localparam int RATIO_N     = 64;
    localparam int RATIO_W     = 20;
    localparam int SAMPLE_W    = 16;
    localparam int KEY_W       = 7;
    localparam int KEY_LOW     = 24;
    localparam int KEY_HIGH    = KEY_LOW + RATIO_N - 1;
    localparam int IDX_W       = $clog2(RATIO_N);
    localparam int COEFF_W     = 16;
    localparam int PROD_W      = PHASE_W + RATIO_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int PRE_W       = 34;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GLIDE_ENABLE = 2'd0,
        REG_BASE_STEP    = 2'd1,
        REG_GLIDE_COEFF  = 2'd2
    } t_cfg_reg;

    localparam logic [PHASE_W-1:0] BASE_STEP_RST   = 32'd11704680;
    localparam logic [COEFF_W-1:0] GLIDE_COEFF_RST = 16'd45;

    typedef logic [RATIO_W-1:0] t_ratio_rom [RATIO_N];

    function automatic int semitone_q16(input int k);
        int v;
        begin
            case (k)
                0:       v = 65536;
                1:       v = 69433;
                2:       v = 73562;
                3:       v = 77936;
                4:       v = 82570;
                5:       v = 87480;
                6:       v = 92682;
                7:       v = 98193;
                8:       v = 104032;
                9:       v = 110218;
                10:      v = 116772;
                default: v = 123715;
            endcase
            return v;
        end
    endfunction

    function automatic t_ratio_rom build_ratio_rom();
        t_ratio_rom rom;
        int oct;
        int b;
        int v;
        begin
            for (int i = 0; i < RATIO_N; i++) begin
                oct = i / 12 - 2;
                b   = semitone_q16(i % 12);
                if (oct >= 0) begin
                    v = b << oct;
                end else begin
                    v = (b + (1 << (-oct - 1))) >> (-oct);
                end
                rom[i] = RATIO_W'(v);
            end
            return rom;
        end
    endfunction

    localparam t_ratio_rom RATIO_ROM = build_ratio_rom();

endpackage

>>> src/polyblep_saw_oscillator_glide.sv
// A request passes target, difference, glide multiply and glide add to output;
// a phase wrap adds the restoring divider (16 quotient bits) and the correction squares.
// The sequencer handles one request at a time
// and reuses one 32x20 multiplier for target, glide step and both correction squares.
// Reset (synchronous, active low): phase, correction and increment clear to zero,
// registers return to glide off, base step 11704680, glide factor 45.
module polyblep_saw_oscillator_glide (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [6:0] note_key, [7] zero
    input  logic        i_s_axis_tlast,   // block_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] sample (signed)
    output logic        o_m_axis_tlast,   // block_last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_TGT  = 10'b00_0000_0010,
        ST_DIF  = 10'b00_0000_0100,
        ST_GMUL = 10'b00_0000_1000,
        ST_GADD = 10'b00_0001_0000,
        ST_DIV  = 10'b00_0010_0000,
        ST_TSQ  = 10'b00_0100_0000,
        ST_USQ  = 10'b00_1000_0000,
        ST_CAR  = 10'b01_0000_0000,
        ST_OUT  = 10'b10_0000_0000
    } t_state;

    localparam int PW = pbsaw_pkg::PHASE_W;

    t_state r_state, n_state;

    logic                               r_glide_en;
    logic [PW-1:0]                      r_base_step;
    logic [pbsaw_pkg::COEFF_W-1:0]      r_glide_coeff;

    logic [pbsaw_pkg::IDX_W-1:0]        r_key_idx;
    logic                               r_last;
    logic [pbsaw_pkg::PROD_W-1:0]       r_prod;
    logic [PW-1:0]                      r_w0;
    logic [PW-1:0]                      r_diff;
    logic                               r_up;
    logic [PW-1:0]                      r_inc;
    logic [PW-1:0]                      r_phase;
    logic [PW-1:0]                      r_corr;
    logic signed [pbsaw_pkg::PRE_W-1:0] r_pre;
    logic [PW-1:0]                      r_rem;
    logic [15:0]                        r_quot;
    logic [3:0]                         r_cnt;
    logic [15:0]                        r_out_data;
    logic                               r_out_last;
    logic                               r_out_valid;

    logic                               in_acc;
    logic [pbsaw_pkg::KEY_W-1:0]        key;
    logic [pbsaw_pkg::IDX_W-1:0]        key_idx;
    logic [PW-1:0]                      mul_a;
    logic [pbsaw_pkg::RATIO_W-1:0]      mul_b;
    logic [pbsaw_pkg::PROD_W-1:0]       mul_res;
    logic [PW-1:0]                      target;
    logic [PW-1:0]                      w0;
    logic [PW-1:0]                      step;
    logic [PW-1:0]                      w_new;
    logic [PW:0]                        np;
    logic [PW:0]                        rem2;
    logic                               rem_ge;
    logic [16:0]                        u_val;
    logic [pbsaw_pkg::PROD_W-1:0]       sq_rnd;
    logic [pbsaw_pkg::PROD_W-1:0]       step_rnd;
    logic signed [34:0]                 s_full;
    logic signed [34:0]                 s_rnd;
    logic signed [18:0]                 s_shift;
    logic [15:0]                        sample;
    logic                               out_free;

    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    always_comb begin
        key = i_s_axis_tdata[pbsaw_pkg::KEY_W-1:0];
        if (key < pbsaw_pkg::KEY_W'(pbsaw_pkg::KEY_LOW)) begin
            key_idx = '0;
        end else if (key > pbsaw_pkg::KEY_W'(pbsaw_pkg::KEY_HIGH)) begin
            key_idx = pbsaw_pkg::IDX_W'(pbsaw_pkg::RATIO_N - 1);
        end else begin
            key_idx = pbsaw_pkg::IDX_W'(key - pbsaw_pkg::KEY_W'(pbsaw_pkg::KEY_LOW));
        end
    end

    assign u_val = 17'h1_0000 - {1'b0, r_quot};

    always_comb begin
        unique case (r_state)
            ST_TGT: begin
                mul_a = r_base_step;
                mul_b = pbsaw_pkg::RATIO_ROM[r_key_idx];
            end
            ST_GMUL: begin
                mul_a = r_diff;
                mul_b = pbsaw_pkg::RATIO_W'(r_glide_coeff);
            end
            ST_TSQ: begin
                mul_a = PW'(r_quot);
                mul_b = pbsaw_pkg::RATIO_W'(r_quot);
            end
            ST_USQ: begin
                mul_a = PW'(u_val);
                mul_b = pbsaw_pkg::RATIO_W'(u_val);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_res = pbsaw_pkg::PROD_W'(mul_a) * pbsaw_pkg::PROD_W'(mul_b);

    assign target   = (|r_prod[pbsaw_pkg::PROD_W-1:48]) ? '1 : r_prod[47:16];
    assign w0       = r_glide_en ? r_inc : target;
    assign step_rnd = r_prod + pbsaw_pkg::PROD_W'(32768);
    assign step     = step_rnd[47:16];
    assign w_new    = r_up ? (r_w0 + step) : (r_w0 - step);
    assign np       = {1'b0, r_phase} + {1'b0, w_new};
    assign rem2     = {r_rem, 1'b0};
    assign rem_ge   = (rem2 >= {1'b0, r_inc});
    assign sq_rnd   = r_prod + pbsaw_pkg::PROD_W'(2);

    always_comb begin
        s_full  = 35'sd1073741824 - 35'(r_pre);
        s_rnd   = s_full + 35'sd32768;
        s_shift = 19'(s_rnd >>> 16);
        if (s_shift > 19'sd32767) begin
            sample = 16'h7FFF;
        end else if (s_shift < -19'sd32768) begin
            sample = 16'h8000;
        end else begin
            sample = s_shift[15:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_TGT;
            ST_TGT:  n_state = ST_DIF;
            ST_DIF:  n_state = ST_GMUL;
            ST_GMUL: n_state = ST_GADD;
            ST_GADD: n_state = np[PW] ? ST_DIV : ST_OUT;
            ST_DIV:  if (r_cnt == 4'd0) n_state = ST_TSQ;
            ST_TSQ:  n_state = ST_USQ;
            ST_USQ:  n_state = ST_CAR;
            ST_CAR:  n_state = ST_OUT;
            ST_OUT:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_glide_en    <= 1'b0;
            r_base_step   <= pbsaw_pkg::BASE_STEP_RST;
            r_glide_coeff <= pbsaw_pkg::GLIDE_COEFF_RST;
            r_inc         <= '0;
            r_phase       <= '0;
            r_corr        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    pbsaw_pkg::REG_GLIDE_ENABLE: r_glide_en    <= i_cfg_data[0];
                    pbsaw_pkg::REG_BASE_STEP:    r_base_step   <= i_cfg_data;
                    pbsaw_pkg::REG_GLIDE_COEFF:  r_glide_coeff <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (r_state == ST_GADD) begin
                r_inc   <= w_new;
                r_phase <= np[PW-1:0];
                if (!np[PW]) begin
                    r_corr <= {1'b0, np[PW-1:1]};
                end
            end
            if (r_state == ST_CAR) begin
                r_corr <= {1'b0, r_phase[PW-1:1]} + PW'(sq_rnd[32:2]);
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key_idx <= key_idx;
            r_last    <= i_s_axis_tlast;
        end
        if (r_state == ST_TGT || r_state == ST_GMUL || r_state == ST_TSQ
            || r_state == ST_USQ) begin
            r_prod <= mul_res;
        end
        if (r_state == ST_DIF) begin
            r_w0 <= w0;
            r_up <= (target >= w0);
            r_diff <= (target >= w0) ? (target - w0) : (w0 - target);
        end
        if (r_state == ST_GADD) begin
            r_pre <= pbsaw_pkg::PRE_W'(r_corr);
            r_rem <= np[PW-1:0];
            r_cnt <= 4'd15;
        end
        if (r_state == ST_DIV) begin
            r_rem  <= rem_ge ? PW'(rem2 - {1'b0, r_inc}) : rem2[PW-1:0];
            r_quot <= {r_quot[14:0], rem_ge};
            r_cnt  <= r_cnt - 4'd1;
        end
        if (r_state == ST_USQ) begin
            r_pre <= r_pre - pbsaw_pkg::PRE_W'(sq_rnd[32:2]);
        end
        if (r_state == ST_OUT && out_free) begin
            r_out_data <= sample;
            r_out_last <= r_last;
        end
    end

endmodule

>>> src/pbsaw_checker.sv
// Port-level checker for the oscillator, bound to the top level.
`include "polyblep_saw_oscillator_glide_assert.svh"

module pbsaw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [1:0]  i_cfg_index,
    input logic [31:0] i_cfg_data
);

    `PBSAW_ASSERT_NEXT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n, !o_m_axis_tvalid)

    `PBSAW_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

    `PBSAW_ASSERT_NEXT(a_no_instant_out, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid, !o_m_axis_tvalid)

    `PBSAW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))

endmodule

bind polyblep_saw_oscillator_glide pbsaw_checker u_pbsaw_checker (.*);
